[rtl/hte_pkg.sv]
package hte_pkg;

   localparam int SYM_W   = 8;
   localparam int CODE_W  = 32;
   localparam int LEN_W   = 6;
   localparam int MODE_W  = 2;
   localparam int ENTRY_W = CODE_W + LEN_W;
   localparam int BYTE_W  = 8;
   // pending byte on top of one full code word
   localparam int BUF_W   = BYTE_W + CODE_W;

   localparam int MAX_CODE_LEN_DEF = 32;
   localparam int NUM_SYMBOLS_DEF  = 256;

   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

   // accepted request, decoded
   typedef struct packed {
      logic encode;
      logic flush;
   } cmd_type;

   // table entry layout
   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] bits;
   } entry_type;

endpackage

[rtl/hte_ram.sv]
module hte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/hte_ctrl.sv]
module hte_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  hte_pkg::cmd_type              cmd,
   input  logic [hte_pkg::ENTRY_W-1:0]   entry_data,
   output logic                          ready,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [hte_pkg::BYTE_W-1:0]    rsp_byte,
   output logic                          rsp_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   localparam int BW = hte_pkg::BYTE_W;
   localparam int CW = hte_pkg::CODE_W;
   localparam int LW = hte_pkg::LEN_W;
   localparam int XW = hte_pkg::BUF_W;

   logic [1:0]    state_ff, state_in;
   logic [BW-1:0] pend_ff, pend_in;
   logic [2:0]    bitpos_ff, bitpos_in;
   logic [XW-1:0] buf_ff, buf_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0] rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;

   hte_pkg::entry_type entry;
   logic [LW-1:0] n_len;
   logic [LW-1:0] shamt;
   logic [CW-1:0] code_al;
   logic [XW-1:0] packed_buf;
   logic [5:0]    total;
   logic          out_free;

   always_comb begin
      entry = hte_pkg::entry_type'(entry_data);
      n_len = (entry.len > LW'(CW)) ? LW'(CW) : entry.len;
      shamt = LW'(CW) - n_len;
      // left-align code; zero length shifts everything out
      code_al = entry.bits << shamt;
      packed_buf = {pend_ff, {CW{1'b0}}} | ({code_al, {BW{1'b0}}} >> bitpos_ff);
      total = {3'b0, bitpos_ff} + n_len;
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      bitpos_in    = bitpos_ff;
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && cmd.encode) begin
               state_in = ST_READ;
            end else if (accept && cmd.flush && bitpos_ff != 3'd0) begin
               buf_in    = {pend_ff, {CW{1'b0}}};
               cnt_in    = 3'd1;
               bitpos_in = 3'd0;
               state_in  = ST_EMIT;
            end
         end
         ST_READ: begin
            buf_in    = packed_buf;
            bitpos_in = total[2:0];
            if (total[5:3] == 3'd0) begin
               pend_in  = packed_buf[XW-1 -: BW];
               state_in = ST_IDLE;
            end else begin
               cnt_in   = total[5:3];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = buf_ff[XW-1 -: BW];
               rsp_last_in  = (cnt_ff == 3'd1);
               buf_in       = buf_ff << BW;
               cnt_in       = cnt_ff - 3'd1;
               if (cnt_ff == 3'd1) begin
                  // leftover partial bits become the pending byte
                  pend_in  = buf_ff[XW-BW-1 -: BW];
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= '0;
         bitpos_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         bitpos_ff    <= bitpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      buf_ff      <= buf_in;
      cnt_ff      <= cnt_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign ready      = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_byte   = rsp_byte_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

[rtl/huffman_table_encoder.sv]
// Huffman code-table encoder, one request at a time.
// Load: no result. Flush: 1 byte when a partial byte is pending.
// Encode: table read, then pack, then 1 byte per cycle (0..4 bytes) while the response
//   side is not stalled; each byte leaves through the byte-wide output register.
// Synchronous active-high reset clears pending bits, bit position and handshake state;
//   the code table holds no reset value and must be loaded before use.
module huffman_table_encoder #(
   parameter int MAX_CODE_LEN = hte_pkg::MAX_CODE_LEN_DEF,
   parameter int NUM_SYMBOLS  = hte_pkg::NUM_SYMBOLS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // symbol[7:0], code_word[39:8], code_length[45:40], zero pad
   input  logic [1:0]  req_tuser,  // mode[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // out_byte[7:0]
   output logic        rsp_tlast   // last_of_run
);

   localparam int AW        = $clog2(NUM_SYMBOLS);
   localparam int LEN_LIMIT = (MAX_CODE_LEN < hte_pkg::CODE_W) ? MAX_CODE_LEN
                                                               : hte_pkg::CODE_W;

   logic [hte_pkg::SYM_W-1:0]   req_symbol;
   logic [hte_pkg::CODE_W-1:0]  req_code;
   logic [hte_pkg::LEN_W-1:0]   req_len;
   logic [hte_pkg::LEN_W-1:0]   len_sat;
   logic                        in_range;
   logic                        accept;
   hte_pkg::cmd_type            cmd;
   hte_pkg::entry_type          wr_entry;
   logic [hte_pkg::ENTRY_W-1:0] rd_entry;
   logic                        tbl_wr;

   // unpack request fields
   assign req_symbol = req_tdata[7:0];
   assign req_code   = req_tdata[39:8];
   assign req_len    = req_tdata[45:40];

   assign accept   = req_tvalid && req_tready;
   // symbols past the table are dropped for both load and encode
   assign in_range = ({1'b0, req_symbol} < 9'(NUM_SYMBOLS));

   // overlong lengths saturate at load time
   assign len_sat = (req_len > hte_pkg::LEN_W'(LEN_LIMIT)) ? hte_pkg::LEN_W'(LEN_LIMIT)
                                                           : req_len;
   assign wr_entry.len  = len_sat;
   assign wr_entry.bits = req_code;

   assign tbl_wr     = accept && (req_tuser == hte_pkg::MODE_LOAD) && in_range;
   assign cmd.encode = (req_tuser == hte_pkg::MODE_ENCODE) && in_range;
   assign cmd.flush  = (req_tuser == hte_pkg::MODE_FLUSH);

   // code table: one write port for loads, one registered read port for encodes
   hte_ram #(
      .WIDTH (hte_pkg::ENTRY_W),
      .DEPTH (NUM_SYMBOLS)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (req_symbol[AW-1:0]),
      .wr_data (wr_entry),
      .rd_addr (req_symbol[AW-1:0]),
      .rd_data (rd_entry)
   );

   // packing and byte sequencing
   hte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cmd        (cmd),
      .entry_data (rd_entry),
      .ready      (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_byte   (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

endmodule

[rtl/hte_checker.sv]
module hte_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   logic req_acc;
   assign req_acc = req_tvalid && req_tready;

   // nothing left over from before reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // a table load never produces bytes
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tuser == hte_pkg::MODE_LOAD && !rsp_tvalid |=> !rsp_tvalid)
      else $error("table load produced a response");

   // no new request while a run of bytes is still going out
   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request ready in the middle of a run");

   // bytes of one run follow without gaps
   a_run_next: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a run of bytes");

endmodule

bind huffman_table_encoder hte_checker u_hte_checker (.*);

[verif/huffman_byte_checker.sv]
module huffman_byte_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,  // symbol[7:0], code_word[39:8], code_length[45:40], zero pad
   input  logic [1:0]  req_tuser,  // mode[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,  // out_byte[7:0]
   input  logic        rsp_tlast,  // last_of_run
   output int          fail_count,
   output int          bytes_owed,
   output int          bytes_checked
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [hte_pkg::BYTE_W-1:0] data;
      logic                       last;
   } coded_byte_type;

   // shadow copy of the code table and the bit packer
   logic [hte_pkg::CODE_W-1:0] code_bits [hte_pkg::NUM_SYMBOLS_DEF];
   logic [hte_pkg::LEN_W-1:0]  code_len  [hte_pkg::NUM_SYMBOLS_DEF];
   logic [hte_pkg::BYTE_W-1:0] acc_byte;
   int                         acc_pos;

   coded_byte_type expected_bytes [$];
   int             fails;
   int             checked;

   function automatic int length_bound();
      return (hte_pkg::MAX_CODE_LEN_DEF < hte_pkg::CODE_W) ? hte_pkg::MAX_CODE_LEN_DEF
                                                           : hte_pkg::CODE_W;
   endfunction

   // appends the bytes one request produces; tlast goes on the final one
   task automatic predict_request(input logic [1:0] mode,
                                  input logic [hte_pkg::SYM_W-1:0] sym,
                                  input logic [hte_pkg::CODE_W-1:0] word,
                                  input logic [hte_pkg::LEN_W-1:0] len);
      int                         n;
      logic [hte_pkg::BYTE_W-1:0] held;
      bit                         held_valid;
      held_valid = 1'b0;
      held       = '0;
      case (mode)
         hte_pkg::MODE_LOAD: begin
            if (int'(sym) < hte_pkg::NUM_SYMBOLS_DEF) begin
               code_bits[sym] = word;
               code_len[sym]  = (int'(len) > length_bound()) ?
                                hte_pkg::LEN_W'(length_bound()) : len;
            end
         end
         hte_pkg::MODE_ENCODE: begin
            if (int'(sym) < hte_pkg::NUM_SYMBOLS_DEF) begin
               n = int'(code_len[sym]);
               for (int i = n; i > 0; i--) begin
                  if (code_bits[sym][i-1])
                     acc_byte[7 - acc_pos] = 1'b1;
                  if (acc_pos == 7) begin
                     if (held_valid)
                        expected_bytes.push_back('{data: held, last: 1'b0});
                     held       = acc_byte;
                     held_valid = 1'b1;
                     acc_byte   = '0;
                     acc_pos    = 0;
                  end else begin
                     acc_pos++;
                  end
               end
               if (held_valid)
                  expected_bytes.push_back('{data: held, last: 1'b1});
            end
         end
         hte_pkg::MODE_FLUSH: begin
            if (acc_pos != 0)
               expected_bytes.push_back('{data: acc_byte, last: 1'b1});
            acc_byte = '0;
            acc_pos  = 0;
         end
         default: ;  // unused mode, dropped
      endcase
   endtask

   task automatic note_failure(input string what);
      fails++;
      if (fails <= MAX_REPORTS)
         $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      coded_byte_type want;
      if (reset) begin
         acc_byte = '0;
         acc_pos  = 0;
      end else begin
         // a response at this edge can only stem from an earlier request
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (expected_bytes.size() == 0) begin
               note_failure($sformatf("unexpected byte %02h last %0b", rsp_tdata, rsp_tlast));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.data)
                  note_failure($sformatf("out_byte exp %02h got %02h", want.data, rsp_tdata));
               if (rsp_tlast !== want.last)
                  note_failure($sformatf("last_of_run exp %0b got %0b (byte %02h)",
                                         want.last, rsp_tlast, want.data));
            end
         end
         if (req_tvalid && req_tready)
            predict_request(req_tuser, req_tdata[7:0], req_tdata[39:8], req_tdata[45:40]);
      end
      fail_count    <= fails;
      bytes_owed    <= expected_bytes.size();
      bytes_checked <= checked;
   end

endmodule

[verif/huffman_table_encoder_test.sv]
module huffman_table_encoder_test;

   timeunit 1ns;
   timeprecision 1ps;

   // mode 3 has no meaning; the block must drop it
   localparam logic [hte_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int ITEMS_PER_PHASE = 40;
   localparam int STALL_LIMIT     = 2000;  // cycles without any handshake
   localparam int SETTLE_CYCLES   = 12;    // margin above the longest encode (up to 4 bytes)

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;  // symbol[7:0], code_word[39:8], code_length[45:40], zero pad
   logic [1:0]  req_tuser  = '0;  // mode[1:0]

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // out_byte[7:0]
   logic        rsp_tlast;        // last_of_run

   int fail_count;
   int bytes_owed;
   int bytes_checked;

   // sender / receiver idle rates in percent, changed per phase
   int req_gap_pct   = 30;
   int rsp_stall_pct = 45;

   int idle_cycles = 0;
   int n_loads     = 0;
   int n_encodes   = 0;
   int n_flushes   = 0;
   int n_dropped   = 0;

   // symbols whose table entry has been written; only these get encoded
   bit       sym_loaded [hte_pkg::NUM_SYMBOLS_DEF];
   int       loaded_syms [$];

   always #5 clock = ~clock;

   huffman_table_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   huffman_byte_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .bytes_owed    (bytes_owed),
      .bytes_checked (bytes_checked)
   );

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // watchdog: a hung handshake on either side ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d bytes owed",
                  idle_cycles, bytes_owed);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // one request: optional idle gap, then hold tvalid until accepted.
   // Called right after a rising edge; tvalid gets one assignment per edge.
   task automatic send_request(input logic [hte_pkg::MODE_W-1:0] mode,
                               input logic [hte_pkg::SYM_W-1:0] sym,
                               input logic [hte_pkg::CODE_W-1:0] word,
                               input logic [hte_pkg::LEN_W-1:0] len);
      while ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 48'({$urandom, $urandom});  // junk while idle
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, len, word, sym};
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      case (mode)
         hte_pkg::MODE_LOAD:   n_loads++;
         hte_pkg::MODE_ENCODE: n_encodes++;
         hte_pkg::MODE_FLUSH:  n_flushes++;
         default:              n_dropped++;
      endcase
   endtask

   task automatic load_entry(input logic [hte_pkg::SYM_W-1:0] sym,
                             input logic [hte_pkg::CODE_W-1:0] word,
                             input logic [hte_pkg::LEN_W-1:0] len);
      if (!sym_loaded[sym]) begin
         sym_loaded[sym] = 1'b1;
         loaded_syms.push_back(int'(sym));
      end
      send_request(hte_pkg::MODE_LOAD, sym, word, len);
   endtask

   // code lengths: mostly short, some long, a few zero or above the 32-bit bound
   function automatic logic [hte_pkg::LEN_W-1:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 5)
         return '0;
      else if (r < 15)
         return hte_pkg::LEN_W'($urandom_range(63, 33));
      else if (r < 30)
         return hte_pkg::LEN_W'($urandom_range(32, 17));
      else
         return hte_pkg::LEN_W'($urandom_range(16, 1));
   endfunction

   // random traffic: mostly encodes of loaded symbols, some reloads and flushes,
   // plus unused-mode noise that does not count toward the phase
   task automatic random_phase(input int count);
      int done;
      int r;
      int pick;
      done = 0;
      while (done < count) begin
         r = $urandom_range(99);
         if (r < 12) begin
            load_entry(hte_pkg::SYM_W'($urandom_range(255)), $urandom, pick_length());
            done++;
         end else if (r < 80) begin
            pick = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
            send_request(hte_pkg::MODE_ENCODE, hte_pkg::SYM_W'(pick), $urandom,
                         hte_pkg::LEN_W'($urandom));
            done++;
         end else if (r < 92) begin
            send_request(hte_pkg::MODE_FLUSH, hte_pkg::SYM_W'($urandom), $urandom,
                         hte_pkg::LEN_W'($urandom));
            done++;
         end else begin
            send_request(MODE_UNUSED, hte_pkg::SYM_W'($urandom), $urandom,
                         hte_pkg::LEN_W'($urandom));
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      load_entry(8'd0,   32'h1234_5678, 6'd0);   // zero-length code
      load_entry(8'd255, 32'hFFFF_FFFF, 6'd32);  // longest legal code, all ones
      load_entry(8'd1,   32'hA5C3_0F96, 6'd63);  // overlong, saturates to 32
      load_entry(8'd2,   32'h0000_0001, 6'd1);   // single bit
      load_entry(8'd3,   32'h0000_0000, 6'd33);  // overlong, all-zero code
      load_entry(8'd128, 32'h0000_0055, 6'd7);
      load_entry(8'd64,  32'h0000_0ABC, 6'd12);
      send_request(hte_pkg::MODE_FLUSH,  8'd0,   '0, '0);  // flush with nothing pending
      send_request(hte_pkg::MODE_ENCODE, 8'd0,   '0, '0);  // zero-length: no byte
      send_request(hte_pkg::MODE_ENCODE, 8'd2,   '0, '0);
      send_request(hte_pkg::MODE_FLUSH,  8'd0,   '0, '0);  // partial byte, zero padded
      send_request(hte_pkg::MODE_ENCODE, 8'd128, '0, '0);
      send_request(hte_pkg::MODE_ENCODE, 8'd2,   '0, '0);  // completes a byte exactly
      send_request(hte_pkg::MODE_ENCODE, 8'd255, '0, '0);  // aligned 32 bits: four bytes
      send_request(hte_pkg::MODE_ENCODE, 8'd2,   '0, '0);
      send_request(hte_pkg::MODE_ENCODE, 8'd255, '0, '0);  // unaligned: four bytes, one left
      send_request(hte_pkg::MODE_ENCODE, 8'd3,   '0, '0);
      send_request(hte_pkg::MODE_ENCODE, 8'd1,   '0, '0);
      send_request(MODE_UNUSED, 8'hFF,  32'hFFFF_FFFF, 6'h3F);  // dropped
      send_request(hte_pkg::MODE_ENCODE, 8'd64,  '0, '0);
      send_request(hte_pkg::MODE_FLUSH,  8'd0,   '0, '0);
      send_request(hte_pkg::MODE_FLUSH,  8'd0,   '0, '0);  // empty again

      // --- random part: sender/receiver idling swapped, then none ---
      random_phase(ITEMS_PER_PHASE);
      req_gap_pct   = 45;
      rsp_stall_pct = 30;
      random_phase(ITEMS_PER_PHASE);
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      random_phase(ITEMS_PER_PHASE);
      req_tvalid <= 1'b0;

      // drain; the watchdog catches bytes that never show up
      @(posedge clock);
      while (bytes_owed != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("requests: %0d loads, %0d encodes, %0d flushes, %0d unused-mode drops",
               n_loads, n_encodes, n_flushes, n_dropped);
      $display("%0d output bytes checked over %0d loaded symbols, %0d failures",
               bytes_checked, loaded_syms.size(), fail_count);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
